FILE: src/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: src/sctt_pkg.sv
// Types and constants of the sorted coordinate time table.
package sctt_pkg;

  localparam int unsigned EntryCountW = 9;

  typedef logic signed [31:0] coord_t;
  typedef logic        [31:0] time_t;

  // Request codes
  localparam logic REQ_CHECK = 1'b0;
  localparam logic REQ_CLEAN = 1'b1;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_INSERTED = 2'd1,
    ST_DROPPED  = 2'd2,
    ST_CLEANED  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_UPDATE,
    FSM_COMPACT
  } fsm_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CAPTURE,
    CELL_REFRESH,
    CELL_INSERT,
    CELL_PURGE,
    CELL_COMPACT
  } cell_op_e;

  // One table entry as seen by a neighbouring cell
  typedef struct packed {
    logic   v;
    coord_t x;
    coord_t y;
    time_t  t;
  } entry_t;

  // Command broadcast to every cell
  typedef struct packed {
    cell_op_e op;
    coord_t   x;
    coord_t   y;
    time_t    t;
  } cell_cmd_t;

  // Neighbours beyond the ends of the row
  localparam entry_t EntryFullEdge  = '{v: 1'b1, x: '0, y: '0, t: '0};
  localparam entry_t EntryEmptyEdge = '{v: 1'b0, x: '0, y: '0, t: '0};

endpackage

FILE: src/sctt_req_if.sv
// Request channel: valid/ready handshake with the request payload.
interface sctt_req_if;
  logic             valid;
  logic             ready;
  logic             req_type;
  sctt_pkg::coord_t coord_x;
  sctt_pkg::coord_t coord_y;
  sctt_pkg::time_t  time_sec;

  modport source (output valid, req_type, coord_x, coord_y, time_sec, input ready);
  modport sink   (input valid, req_type, coord_x, coord_y, time_sec, output ready);
endinterface

FILE: src/sctt_rsp_if.sv
// Response channel: valid/ready handshake with the response payload.
interface sctt_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       status;
  logic [sctt_pkg::EntryCountW-1:0] entry_count;

  modport source (output valid, status, entry_count, input ready);
  modport sink   (input valid, status, entry_count, output ready);
endinterface

FILE: src/sctt_cell.sv
// One table slot: stored entry, key comparison, and neighbour shifts.
module sctt_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sctt_pkg::cell_cmd_t cmd_i,
  input  sctt_pkg::entry_t    left_i,
  input  logic                left_after_i,
  input  sctt_pkg::entry_t    right_i,
  output sctt_pkg::entry_t    entry_o,
  output logic                eq_o,
  output logic                after_o
);
  import sctt_pkg::*;

  logic   v_q, v_d;
  coord_t x_q, x_d;
  coord_t y_q, y_d;
  time_t  t_q, t_d;
  logic   eq_q, eq_d;
  logic   after_q, after_d;

  // Next entry from the broadcast command and the neighbours
  always_comb begin
    v_d     = v_q;
    x_d     = x_q;
    y_d     = y_q;
    t_d     = t_q;
    eq_d    = eq_q;
    after_d = after_q;
    case (cmd_i.op)
      CELL_CAPTURE: begin
        eq_d    = v_q && (x_q == cmd_i.x) && (y_q == cmd_i.y);
        after_d = v_q && ((y_q > cmd_i.y) || ((y_q == cmd_i.y) && (x_q > cmd_i.x)));
      end
      CELL_REFRESH: begin
        if (eq_q) begin
          t_d = cmd_i.t;
        end
      end
      CELL_INSERT: begin
        // take the left entry while the tail moves up, or the key at the gap
        if (left_after_i) begin
          v_d = 1'b1;
          x_d = left_i.x;
          y_d = left_i.y;
          t_d = left_i.t;
        end else if ((!v_q || after_q) && left_i.v) begin
          v_d = 1'b1;
          x_d = cmd_i.x;
          y_d = cmd_i.y;
          t_d = cmd_i.t;
        end
      end
      CELL_PURGE: begin
        v_d = v_q && (t_q > cmd_i.t);
      end
      CELL_COMPACT: begin
        // pull the right entry into a hole; give ours away to a hole on the left
        if (!v_q && right_i.v) begin
          v_d = 1'b1;
          x_d = right_i.x;
          y_d = right_i.y;
          t_d = right_i.t;
        end else if (v_q && !left_i.v) begin
          v_d = 1'b0;
        end
      end
      default: begin
        v_d = v_q;
      end
    endcase
  end

  // Control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= 1'b0;
      eq_q    <= 1'b0;
      after_q <= 1'b0;
    end else begin
      v_q     <= v_d;
      eq_q    <= eq_d;
      after_q <= after_d;
    end
  end

  // Entry payload
  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    t_q <= t_d;
  end

  assign entry_o = '{v: v_q, x: x_q, y: y_q, t: t_q};
  assign eq_o    = eq_q;
  assign after_o = after_q;

endmodule

FILE: src/sorted_coordinate_time_table_unit.sv
// Top level of the sorted coordinate time table: cell row and sequencer.
`include "assert_macros.svh"

// The table is a row of TABLE_DEPTH cells kept in ascending (y, x) order, each
// cell holding one coordinate with its last-seen time. In a check, every cell
// compares the key with its entry in the transfer cycle; then, once the output
// register is free, the matching cell refreshes its time or the cells above
// the sorted position move up by one while the gap takes the new coordinate
// (or it is dropped when the table is full). In a clean, stale entries are
// cleared in the transfer cycle, then entries move down one cell per cycle
// towards holes until the row is packed. A new request is taken once the
// previous one has finished; one finished response may wait in the output
// register meanwhile. entry_count is the count modulo 512.
module sorted_coordinate_time_table_unit #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sctt_req_if.sink   req_i,
  sctt_rsp_if.source rsp_o
);
  import sctt_pkg::*;

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  entry_t                 ent [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] eq_vec;
  logic [TABLE_DEPTH-1:0] after_vec;
  logic [TABLE_DEPTH-1:0] move_vec;
  logic [TABLE_DEPTH-1:0] last_vec;
  cell_cmd_t              cmd;

  fsm_e    state_q, state_d;
  coord_t  key_x_q, key_x_d;
  coord_t  key_y_q, key_y_d;
  time_t   key_t_q, key_t_d;
  logic    out_v_q, out_v_d;
  status_e out_st_q, out_st_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] cnt_packed;
  logic          out_free;
  logic          found;
  logic          full;

  // Row of cells, each linked to both neighbours
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    entry_t left;
    entry_t right;
    logic   left_after;

    if (i == 0) begin : g_first
      assign left       = EntryFullEdge;
      assign left_after = 1'b0;
    end else begin : g_inner_l
      assign left       = ent[i-1];
      assign left_after = after_vec[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign right = EntryEmptyEdge;
    end else begin : g_inner_r
      assign right = ent[i+1];
    end

    sctt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .left_i       (left),
      .left_after_i (left_after),
      .right_i      (right),
      .entry_o      (ent[i]),
      .eq_o         (eq_vec[i]),
      .after_o      (after_vec[i])
    );

    assign move_vec[i] = !ent[i].v && right.v;
    assign last_vec[i] = ent[i].v && !right.v;
  end

  // Entry count of a packed row: position of the last occupied cell plus one
  always_comb begin
    cnt_packed = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (last_vec[i]) begin
        cnt_packed = cnt_packed | CW'(i + 1);
      end
    end
  end

  assign found    = |eq_vec;
  assign full     = (count_q == CW'(TABLE_DEPTH));
  assign out_free = !out_v_q || rsp_o.ready;

  // Sequencer: next state, cell commands and response
  always_comb begin
    state_d  = state_q;
    key_x_d  = key_x_q;
    key_y_d  = key_y_q;
    key_t_d  = key_t_q;
    count_d  = count_q;
    out_v_d  = out_v_q && !rsp_o.ready;
    out_st_d = out_st_q;
    cmd      = '{op: CELL_HOLD, x: key_x_q, y: key_y_q, t: key_t_q};
    case (state_q)
      FSM_IDLE: begin
        if (req_i.valid) begin
          key_x_d = req_i.coord_x;
          key_y_d = req_i.coord_y;
          key_t_d = req_i.time_sec;
          cmd.x   = req_i.coord_x;
          cmd.y   = req_i.coord_y;
          cmd.t   = req_i.time_sec;
          if (req_i.req_type == REQ_CLEAN) begin
            cmd.op  = CELL_PURGE;
            state_d = FSM_COMPACT;
          end else begin
            cmd.op  = CELL_CAPTURE;
            state_d = FSM_UPDATE;
          end
        end
      end
      FSM_UPDATE: begin
        if (out_free) begin
          out_v_d = 1'b1;
          state_d = FSM_IDLE;
          if (found) begin
            cmd.op   = CELL_REFRESH;
            out_st_d = ST_FOUND;
          end else if (full) begin
            out_st_d = ST_DROPPED;
          end else begin
            cmd.op   = CELL_INSERT;
            out_st_d = ST_INSERTED;
            count_d  = count_q + CW'(1);
          end
        end
      end
      FSM_COMPACT: begin
        if (|move_vec) begin
          cmd.op = CELL_COMPACT;
        end else if (out_free) begin
          out_v_d  = 1'b1;
          out_st_d = ST_CLEANED;
          count_d  = cnt_packed;
          state_d  = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      out_v_q <= 1'b0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      out_v_q <= out_v_d;
      count_q <= count_d;
    end
  end

  // Request key and response status
  always_ff @(posedge clk_i) begin
    key_x_q  <= key_x_d;
    key_y_q  <= key_y_d;
    key_t_q  <= key_t_d;
    out_st_q <= out_st_d;
  end

  assign req_i.ready       = (state_q == FSM_IDLE);
  assign rsp_o.valid       = out_v_q;
  assign rsp_o.status      = out_st_q;
  assign rsp_o.entry_count = EntryCountW'(count_q);

  // Checks
  `ASSERT_PROP(a_count_bound, clk_i, rst_ni, count_q <= CW'(TABLE_DEPTH), "count above depth")
  `ASSERT_PROP(a_idle_packed, clk_i, rst_ni, (state_q == FSM_IDLE) |-> (move_vec == '0), "row not packed when idle")
  `ASSERT_PROP(a_single_match, clk_i, rst_ni, $onehot0(eq_vec), "coordinate stored twice")
  `ASSERT_NEVER(a_drop_not_full, clk_i, rst_ni, out_v_q && (out_st_q == ST_DROPPED) && !full, "drop reported with room left")

endmodule
